>>> hw/rtl/tcw_pkg.sv
// Shared types and constants for the TCP congestion window update block.
// Used by tcw_serial_div and tcp_congestion_window_update; depends on nothing.
`default_nettype none

package tcw_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MSS_W     = 16;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

  // Register index, taken from paddr[2] (registers sit every four bytes).
  localparam logic REG_MSS = 1'b0;

  localparam logic [MSS_W-1:0]  MSS_RESET    = 16'd536;
  localparam logic [WORD_W-1:0] WINDOW_RESET = 32'd1;
  localparam logic [WORD_W-1:0] THRESH_RESET = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACK        = 3'd0,
    CMD_DUPACK     = 3'd1,
    CMD_TRIPLE     = 3'd2,
    CMD_TIMEOUT    = 3'd3,
    CMD_CONGESTION = 3'd4,
    CMD_RECOVERED  = 3'd5,
    CMD_INIT       = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADD3,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcw_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on tcw_pkg for the word width and the status struct.
`default_nettype none

module tcw_serial_div
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output div_sts_t               sts,
  output logic      [WORD_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    rem_r;
  logic [WORD_W-1:0]    quo_r;
  logic [WORD_W-1:0]    dvs_r;

  logic [WORD_W:0]      shifted;
  logic [WORD_W:0]      diff;
  logic [WORD_W-1:0]    rem_nxt;
  logic [WORD_W-1:0]    quo_nxt;

  // The partial remainder stays below the divisor, so the shifted value is
  // below twice the divisor and the top bit of the difference is the borrow.
  always_comb begin
    shifted = {rem_r, quo_r[WORD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[WORD_W]) begin
      rem_nxt = diff[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/tcp_congestion_window_update.sv
// Congestion window and slow-start threshold for one TCP connection.
// Each accepted word passes through EXEC and FINISH; a triple dupack adds the ADD3 step, and an
// ACK in congestion avoidance runs the bit-serial divider (DIV_GO, DIV_WAIT) before FINISH.
// One word is in work at a time; the next is taken once the result is in the output register,
// and FINISH holds the word while an earlier result still waits on a stall at the output.
// Reset (synchronous, active low): window 1, threshold all ones, MSS 536, no result pending.
`default_nettype none

module tcp_congestion_window_update
  import tcw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [WORD_W-1:0]  in_advertised_window,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [WORD_W-1:0]  out_congestion_window,
  output logic      [WORD_W-1:0]  out_slow_start_threshold,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  state_t            state_r, state_nxt;
  logic [MSS_W-1:0]  mss_r;
  logic [WORD_W-1:0] window_r, window_nxt;
  logic [WORD_W-1:0] thresh_r, thresh_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [WORD_W-1:0] adv_r;
  logic [WORD_W-1:0] product_r, product_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_window_r;
  logic [WORD_W-1:0] out_thresh_r;
  logic              load_out;

  logic              div_start;
  div_sts_t          div_sts;
  logic [WORD_W-1:0] div_quo;

  logic [WORD_W-1:0] grow_amt;
  logic [WORD_W:0]   grow_sum;
  logic [WORD_W-1:0] grown;
  logic [WORD_W-1:0] cong_base;
  logic [WORD_W-1:0] cong_half;
  logic [WORD_W-1:0] mss_x2;
  logic [WORD_W-1:0] mss_x3;
  logic [WORD_W-1:0] cong_thresh;
  logic              in_accept;

  assign in_accept = in_valid && !in_stall;

  assign mss_x2 = {{(WORD_W-MSS_W-1){1'b0}}, mss_r, 1'b0};
  assign mss_x3 = mss_x2 + {{(WORD_W-MSS_W){1'b0}}, mss_r};

  assign grow_amt = (state_r == ST_DIV_WAIT) ? div_quo : {{(WORD_W-MSS_W){1'b0}}, mss_r};

  // A step that would wrap, or adds nothing, leaves the window as it is.
  assign grow_sum = {1'b0, window_r} + {1'b0, grow_amt};
  assign grown    = (!grow_sum[WORD_W] && (grow_amt != '0)) ? grow_sum[WORD_W-1:0]
                                                             : window_r;

  assign cong_base   = (window_r > adv_r) ? adv_r : window_r;
  assign cong_half   = {1'b0, cong_base[WORD_W-1:1]};
  assign cong_thresh = (cong_half < mss_x2) ? mss_x2 : cong_half;

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    thresh_nxt    = thresh_r;
    product_nxt   = product_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    load_out      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
        case (cmd_r)
          CMD_ACK: begin
            if (window_r < thresh_r) begin
              window_nxt = grown;
            end else if (window_r != '0) begin
              product_nxt = {{(WORD_W-MSS_W){1'b0}}, mss_r} *
                            {{(WORD_W-MSS_W){1'b0}}, mss_r};
              state_nxt   = ST_DIV_GO;
            end
          end
          CMD_DUPACK: begin
            window_nxt = grown;
          end
          CMD_TRIPLE: begin
            thresh_nxt = cong_thresh;
            state_nxt  = ST_ADD3;
          end
          CMD_TIMEOUT: begin
            thresh_nxt = cong_thresh;
            window_nxt = {{(WORD_W-MSS_W){1'b0}}, mss_r};
          end
          CMD_CONGESTION: begin
            thresh_nxt = cong_thresh;
          end
          CMD_RECOVERED: begin
            window_nxt = thresh_r;
          end
          CMD_INIT: begin
            window_nxt = (window_r == WINDOW_RESET) ? mss_x2
                                                    : {{(WORD_W-MSS_W){1'b0}}, mss_r};
          end
          default: begin
          end
        endcase
      end
      ST_ADD3: begin
        window_nxt = thresh_r + mss_x3;
        state_nxt  = ST_FINISH;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          window_nxt = grown;
          state_nxt  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RESET;
      thresh_r    <= THRESH_RESET;
      mss_r       <= MSS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
      thresh_r    <= thresh_nxt;
      if (psel && penable && pwrite && (paddr[2] == REG_MSS)) begin
        mss_r <= pwdata[MSS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    product_r <= product_nxt;
    if (in_accept) begin
      cmd_r <= in_cmd;
      adv_r <= in_advertised_window;
    end
    if (load_out) begin
      out_window_r <= window_r;
      out_thresh_r <= thresh_r;
    end
  end

  tcw_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product_r),
    .divisor  (window_r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign in_stall                 = (state_r != ST_IDLE);
  assign out_valid                = out_valid_r;
  assign out_congestion_window    = out_window_r;
  assign out_slow_start_threshold = out_thresh_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MSS) ? {{(PDATA_W-MSS_W){1'b0}}, mss_r} : '0;

endmodule

`default_nettype wire

>>> tb/sv/tcp_congestion_window_update_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tcp_congestion_window_update: plays ACK, loss and recovery
// events through the block and checks window and threshold of every result word.
// Depends on tcw_pkg and the block's RTL.

module tcp_congestion_window_update_tb;
  import tcw_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] adv;
  } tcp_event_t;

  typedef struct {
    logic [WORD_W-1:0] cwnd;
    logic [WORD_W-1:0] ssthresh;
  } window_pair_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd = '0;
  logic [WORD_W-1:0]  in_advertised_window = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WORD_W-1:0]  out_congestion_window;
  logic [WORD_W-1:0]  out_slow_start_threshold;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tcp_event_t   pending_events[$];
  window_pair_t expected_windows[$];

  logic [WORD_W-1:0] cwnd_model;
  logic [WORD_W-1:0] ssthresh_model;
  logic [WORD_W-1:0] mss_model;

  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          idling = 1'b0;
  bit          in_fire = 1'b0;

  always #5 clk = ~clk;

  tcp_congestion_window_update i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_cmd                   (in_cmd),
    .in_advertised_window     (in_advertised_window),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_congestion_window    (out_congestion_window),
    .out_slow_start_threshold (out_slow_start_threshold),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  // Increments whose 32-bit sum would not exceed the window are dropped.
  function automatic void add_to_cwnd(input logic [WORD_W-1:0] amount);
    logic [WORD_W-1:0] sum;
    sum = cwnd_model + amount;
    if (sum > cwnd_model) begin
      cwnd_model = sum;
    end
  endfunction

  function automatic void apply_event(input tcp_event_t ev);
    logic [WORD_W-1:0] limit;
    case (ev.cmd)
      CMD_ACK: begin
        if (cwnd_model < ssthresh_model) begin
          add_to_cwnd(mss_model);
        end else if (cwnd_model != '0) begin
          add_to_cwnd((mss_model * mss_model) / cwnd_model);
        end
      end
      CMD_DUPACK: begin
        add_to_cwnd(mss_model);
      end
      CMD_TRIPLE, CMD_TIMEOUT, CMD_CONGESTION: begin
        limit = (cwnd_model > ev.adv) ? ev.adv : cwnd_model;
        ssthresh_model = limit >> 1;
        if (ssthresh_model < 2 * mss_model) begin
          ssthresh_model = 2 * mss_model;
        end
        if (ev.cmd == CMD_TRIPLE) begin
          cwnd_model = ssthresh_model + 3 * mss_model;
        end else if (ev.cmd == CMD_TIMEOUT) begin
          cwnd_model = mss_model;
        end
      end
      CMD_RECOVERED: begin
        cwnd_model = ssthresh_model;
      end
      CMD_INIT: begin
        cwnd_model = (cwnd_model == 1) ? 2 * mss_model : mss_model;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, what, want, got);
    end
  endfunction

  // Result check, prediction of accepted words and the watchdog.
  always @(posedge clk) begin
    window_pair_t want;
    tcp_event_t   ev;
    bit           out_fire;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (out_fire) begin
      if (expected_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result word with nothing expected: window 0x%08h, threshold 0x%08h",
                   $time, out_congestion_window, out_slow_start_threshold);
        end
      end else begin
        want = expected_windows.pop_front();
        if (out_congestion_window !== want.cwnd) begin
          flag_mismatch("congestion_window", want.cwnd, out_congestion_window);
        end
        if (out_slow_start_threshold !== want.ssthresh) begin
          flag_mismatch("slow_start_threshold", want.ssthresh, out_slow_start_threshold);
        end
      end
    end
    if (in_fire) begin
      ev.cmd = in_cmd;
      ev.adv = in_advertised_window;
      apply_event(ev);
      expected_windows.push_back('{cwnd_model, ssthresh_model});
      words_taken++;
    end
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL tcp_congestion_window_update");
      $finish;
    end
  end

  // Sender and receiver, both moving on the falling edge.
  always @(negedge clk) begin
    tcp_event_t ev;
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left == 0 && idling && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 18);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        ev = pending_events.pop_front();
        in_cmd               <= ev.cmd;
        in_advertised_window <= ev.adv;
        in_valid             <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (rst_n && stall_left == 0 && idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) begin
      stall_left--;
    end
  end

  function automatic void push_event(input logic [CMD_W-1:0] cmd,
                                     input logic [WORD_W-1:0] adv);
    pending_events.push_back('{cmd, adv});
    words_queued++;
  endfunction

  function automatic logic [WORD_W-1:0] pick_adv();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 400000);
      3:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Mostly Reno-shaped episodes, with some loose commands mixed in.
  task automatic queue_reno_traffic(input int unsigned count);
    int unsigned target;
    target = words_queued + count;
    while (words_queued < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 12)) push_event(CMD_ACK, pick_adv());
        end
        4, 5: begin
          repeat ($urandom_range(0, 3)) push_event(CMD_DUPACK, pick_adv());
          push_event(CMD_TRIPLE, pick_adv());
          repeat ($urandom_range(0, 5)) push_event(CMD_DUPACK, pick_adv());
          push_event(CMD_RECOVERED, pick_adv());
        end
        6: begin
          push_event(CMD_TIMEOUT, pick_adv());
          repeat ($urandom_range(0, 6)) push_event(CMD_ACK, pick_adv());
        end
        7: begin
          push_event(CMD_CONGESTION, pick_adv());
        end
        8: begin
          push_event(CMD_INIT, pick_adv());
        end
        default: begin
          repeat ($urandom_range(1, 4)) push_event(CMD_W'($urandom_range(0, 7)), $urandom);
        end
      endcase
    end
  endtask

  task automatic wait_for_idle();
    do @(negedge clk); while (words_taken != words_queued || expected_windows.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mss(input logic [MSS_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MSS, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mss_model = WORD_W'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [MSS_W-1:0] mss_plan[8];
    cwnd_model     = WINDOW_RESET;
    ssthresh_model = THRESH_RESET;
    mss_model      = WORD_W'(MSS_RESET);
    mss_plan = '{16'd1460, 16'hFFFF, 16'd1, 16'd536, 16'd0, 16'd9000, 16'd2, 16'd0};
    mss_plan[4] = MSS_W'($urandom_range(1, 65535));
    mss_plan[7] = MSS_W'($urandom_range(1, 65535));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idling = 1'b1;

    // Reset MSS. The all-ones threshold lets the window reach the top, where growth must stop.
    push_event(CMD_RECOVERED, '0);
    push_event(CMD_DUPACK, '0);
    push_event(CMD_ACK, '0);
    push_event(CMD_TRIPLE, '1);
    push_event(CMD_DUPACK, 32'h5555_5555);
    push_event(CMD_RECOVERED, 32'hAAAA_AAAA);
    push_event(CMD_ACK, '1);
    push_event(CMD_ACK, '0);
    push_event(CMD_UNUSED, '1);
    push_event(CMD_CONGESTION, '0);
    push_event(CMD_TIMEOUT, 32'h8000_0000);
    push_event(CMD_INIT, '1);
    wait_for_idle();

    // A zero MSS drives the window to zero, so an ACK in avoidance must not divide.
    write_mss(16'd0);
    push_event(CMD_CONGESTION, '0);
    push_event(CMD_TIMEOUT, '0);
    push_event(CMD_ACK, '0);
    push_event(CMD_DUPACK, '1);
    push_event(CMD_INIT, '0);
    push_event(CMD_TRIPLE, '0);
    wait_for_idle();

    // With an MSS of one, a timeout leaves a window of one for init to double.
    write_mss(16'd1);
    push_event(CMD_TIMEOUT, 32'd7);
    push_event(CMD_INIT, '0);
    push_event(CMD_DUPACK, '0);
    push_event(CMD_ACK, '0);
    wait_for_idle();

    write_mss(16'hFFFF);
    push_event(CMD_INIT, '0);
    push_event(CMD_ACK, '0);
    push_event(CMD_TRIPLE, '1);
    push_event(CMD_ACK, '1);

    foreach (mss_plan[i]) begin
      wait_for_idle();
      write_mss(mss_plan[i]);
      idling = (i % 3 != 2) && (i != 7);
      queue_reno_traffic(112);
    end
    wait_for_idle();

    if (mismatches == 0) begin
      $display("PASS tcp_congestion_window_update");
    end else begin
      $display("FAIL tcp_congestion_window_update");
    end
    $finish;
  end

endmodule
